### rtl/core/lftc_pkg.sv
package lftc_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int NUM_SAMPLES = 8;

    // configuration port
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [6:0]             t_speed;
    typedef logic [4:0]             t_gain;
    typedef logic [1:0]             t_mode;
    typedef logic [2:0]             t_phase;
    typedef logic [2:0]             t_reg_idx;

    // register indexes, byte address is 4 * index
    localparam t_reg_idx REG_NORMAL_BASE = 3'd0;
    localparam t_reg_idx REG_NORMAL_GAIN = 3'd1;
    localparam t_reg_idx REG_SLOW_BASE   = 3'd2;
    localparam t_reg_idx REG_SLOW_GAIN   = 3'd3;
    localparam t_reg_idx REG_SPEED_LIMIT = 3'd4;

    localparam t_speed RST_NORMAL_BASE = 7'd50;
    localparam t_gain  RST_NORMAL_GAIN = 5'd12;
    localparam t_speed RST_SLOW_BASE   = 7'd20;
    localparam t_gain  RST_SLOW_GAIN   = 5'd8;
    localparam t_speed RST_SPEED_LIMIT = 7'd70;

    // track modes
    localparam t_mode MODE_NORMAL    = 2'd0;
    localparam t_mode MODE_CIRCLE    = 2'd1;
    localparam t_mode MODE_LEFT_INT  = 2'd2;
    localparam t_mode MODE_RIGHT_INT = 2'd3;

    // sequence phases
    localparam t_phase PH_ENTRY = 3'd0;
    localparam t_phase PH_SEQ0  = 3'd1;
    localparam t_phase PH_SEQ1  = 3'd2;
    localparam t_phase PH_SEQ2  = 3'd3;
    localparam t_phase PH_SEQ3  = 3'd4;
    localparam t_phase PH_SEQ4  = 3'd5;

    // sensor weights, outer sensors count most
    localparam logic [1:0] WEIGHT [NUM_SAMPLES] = '{
        2'd3, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd3
    };

    typedef struct packed {
        t_speed normal_base;
        t_gain  normal_gain;
        t_speed slow_base;
        t_gain  slow_gain;
        t_speed speed_limit;
    } t_cfg;

    typedef struct packed {
        logic [2:0] left_sum;
        logic [2:0] right_sum;
        logic       full;
        logic       left_half;
        logic       right_half;
        logic       mid;
        logic       blank;
        logic       out_line;
    } t_sig;

    typedef struct packed {
        t_speed left_speed;
        t_speed right_speed;
        t_mode  mode;
        t_phase phase;
    } t_result;

endpackage

### rtl/core/lftc_cfg_regs.sv
module lftc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lftc_pkg::ADDR_BITS-1:0] paddr,
    input  logic [lftc_pkg::DATA_BITS-1:0] pwdata,
    output logic [lftc_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output lftc_pkg::t_cfg                 o_cfg
);
    import lftc_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_BITS-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_NORMAL_BASE: n_cfg.normal_base = pwdata[6:0];
                REG_NORMAL_GAIN: n_cfg.normal_gain = pwdata[4:0];
                REG_SLOW_BASE:   n_cfg.slow_base   = pwdata[6:0];
                REG_SLOW_GAIN:   n_cfg.slow_gain   = pwdata[4:0];
                REG_SPEED_LIMIT: n_cfg.speed_limit = pwdata[6:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_base <= RST_NORMAL_BASE;
            r_cfg.normal_gain <= RST_NORMAL_GAIN;
            r_cfg.slow_base   <= RST_SLOW_BASE;
            r_cfg.slow_gain   <= RST_SLOW_GAIN;
            r_cfg.speed_limit <= RST_SPEED_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_NORMAL_BASE: prdata = {{(DATA_BITS-7){1'b0}}, r_cfg.normal_base};
            REG_NORMAL_GAIN: prdata = {{(DATA_BITS-5){1'b0}}, r_cfg.normal_gain};
            REG_SLOW_BASE:   prdata = {{(DATA_BITS-7){1'b0}}, r_cfg.slow_base};
            REG_SLOW_GAIN:   prdata = {{(DATA_BITS-5){1'b0}}, r_cfg.slow_gain};
            REG_SPEED_LIMIT: prdata = {{(DATA_BITS-7){1'b0}}, r_cfg.speed_limit};
            default:         prdata = '0;
        endcase
    end

endmodule

### rtl/core/lftc_detect.sv
module lftc_detect (
    input  lftc_pkg::t_sample i_samples [lftc_pkg::NUM_SAMPLES],
    output lftc_pkg::t_sig    o_sig
);
    import lftc_pkg::*;

    t_sample                w_min_a [4];
    t_sample                w_min_b [2];
    t_sample                w_min;
    logic [SAMPLE_BITS+2:0] w_scaled;
    logic [SAMPLE_BITS:0]   w_thr;
    logic [1:0]             w_wt [NUM_SAMPLES];
    logic [2:0]             w_ls;
    logic [1:0]             w_ms;
    logic [2:0]             w_rs;

    // three-level minimum tree
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_min_a[i] = (i_samples[2*i+1] < i_samples[2*i]) ?
                         i_samples[2*i+1] : i_samples[2*i];
        end
        for (int i = 0; i < 2; i++) begin
            w_min_b[i] = (w_min_a[2*i+1] < w_min_a[2*i]) ? w_min_a[2*i+1] : w_min_a[2*i];
        end
        w_min = (w_min_b[1] < w_min_b[0]) ? w_min_b[1] : w_min_b[0];
    end

    // threshold is floor(min * 5 / 4)
    assign w_scaled = {1'b0, w_min, 2'b00} + {3'b000, w_min};
    assign w_thr    = w_scaled[SAMPLE_BITS+2:2];

    always_comb begin
        for (int i = 0; i < NUM_SAMPLES; i++) begin
            w_wt[i] = ({1'b0, i_samples[i]} < w_thr) ? WEIGHT[i] : 2'd0;
        end
    end

    assign w_ls = {1'b0, w_wt[0]} + {1'b0, w_wt[1]} + {1'b0, w_wt[2]};
    assign w_ms = w_wt[3] + w_wt[4];
    assign w_rs = {1'b0, w_wt[5]} + {1'b0, w_wt[6]} + {1'b0, w_wt[7]};

    always_comb begin
        o_sig.left_sum   = w_ls;
        o_sig.right_sum  = w_rs;
        o_sig.full       = (w_ls >= 3'd5) && (w_ms >= 2'd2) && (w_rs >= 3'd5);
        o_sig.left_half  = (w_ls >= 3'd5) && (w_ms >= 2'd1);
        o_sig.right_half = (w_ms >= 2'd1) && (w_rs >= 3'd5);
        o_sig.mid        = (w_ls == 3'd0) && (w_ms >= 2'd2) && (w_rs == 3'd0);
        o_sig.blank      = (w_ls == 3'd0) && (w_ms == 2'd0) && (w_rs == 3'd0);
        o_sig.out_line   = !o_sig.full &&
                           (((w_ls >= 3'd1) && (w_ms >= 2'd2) && (w_rs >= 3'd2)) ||
                            ((w_ls == 3'd0) && (w_ms >= 2'd2) && (w_rs >= 3'd3)));
    end

endmodule

### rtl/core/lftc_track.sv
module lftc_track (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  lftc_pkg::t_sig    i_sig,
    input  lftc_pkg::t_cfg    i_cfg,
    output lftc_pkg::t_result o_next
);
    import lftc_pkg::*;

    t_mode             r_mode;
    t_mode             n_mode;
    t_phase            r_phase;
    t_phase            n_phase;
    t_speed            r_held_left;
    t_speed            r_held_right;
    logic signed [8:0] w_lsp;
    logic signed [8:0] w_rsp;

    // base - gain * sum, may go negative
    function automatic logic signed [8:0] steer(input t_speed base, input t_gain gain,
                                                input logic [2:0] sum);
        logic [7:0] prod;
        prod  = {3'b000, gain} * {5'b00000, sum};
        steer = $signed({2'b00, base}) - $signed({1'b0, prod});
    endfunction

    function automatic t_speed clamp(input logic signed [8:0] v, input t_speed lim);
        if (v < 0) begin
            clamp = '0;
        end else if (v[7:0] > {1'b0, lim}) begin
            clamp = lim;
        end else begin
            clamp = v[6:0];
        end
    endfunction

    // track state machine
    always_comb begin
        n_mode  = r_mode;
        n_phase = r_phase;
        if (r_mode == MODE_NORMAL) begin
            n_phase = PH_ENTRY;
            priority if (i_sig.full) begin
                n_mode = MODE_CIRCLE;
            end else if (i_sig.left_half) begin
                n_mode = MODE_LEFT_INT;
            end else if (i_sig.right_half) begin
                n_mode = MODE_RIGHT_INT;
            end else begin
                n_mode = MODE_NORMAL;
            end
        end else if (r_phase == PH_ENTRY) begin
            n_phase = PH_SEQ0;
        end else if (r_mode == MODE_CIRCLE) begin
            unique case (r_phase)
                PH_SEQ0: if (i_sig.mid)      n_phase = PH_SEQ1;
                PH_SEQ1: if (i_sig.full)     n_phase = PH_SEQ2;
                PH_SEQ2: if (i_sig.mid)      n_phase = PH_SEQ3;
                PH_SEQ3: if (i_sig.out_line) n_phase = PH_SEQ4;
                PH_SEQ4: begin
                    if (i_sig.mid) begin
                        n_mode  = MODE_NORMAL;
                        n_phase = PH_ENTRY;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end else begin
            unique case (r_phase)
                PH_SEQ0: if (i_sig.blank) n_phase = PH_SEQ1;
                PH_SEQ1: begin
                    if (i_sig.mid) begin
                        n_mode  = MODE_NORMAL;
                        n_phase = PH_ENTRY;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // speed choice from the updated mode and phase, sequence entry phases hold
    always_comb begin
        w_lsp = $signed({2'b00, r_held_left});
        w_rsp = $signed({2'b00, r_held_right});
        if (n_mode == MODE_NORMAL) begin
            w_lsp = steer(i_cfg.normal_base, i_cfg.normal_gain, i_sig.left_sum);
            w_rsp = steer(i_cfg.normal_base, i_cfg.normal_gain, i_sig.right_sum);
        end else if (n_mode == MODE_CIRCLE) begin
            if (n_phase == PH_SEQ0 || n_phase == PH_SEQ1 || n_phase == PH_SEQ3) begin
                w_lsp = steer(i_cfg.slow_base, i_cfg.slow_gain, i_sig.left_sum);
                w_rsp = steer(i_cfg.slow_base, i_cfg.slow_gain, i_sig.right_sum);
            end else if (n_phase == PH_SEQ2 || n_phase == PH_SEQ4) begin
                w_lsp = $signed({2'b00, i_cfg.slow_base});
                w_rsp = '0;
            end
        end else begin
            if (n_phase == PH_SEQ0) begin
                w_lsp = $signed({2'b00, i_cfg.slow_base});
                w_rsp = $signed({2'b00, i_cfg.slow_base});
            end else if (n_phase == PH_SEQ1) begin
                if (n_mode == MODE_LEFT_INT) begin
                    w_lsp = '0;
                    w_rsp = $signed({2'b00, i_cfg.slow_base});
                end else begin
                    w_lsp = $signed({2'b00, i_cfg.slow_base});
                    w_rsp = '0;
                end
            end
        end
    end

    always_comb begin
        o_next.left_speed  = clamp(w_lsp, i_cfg.speed_limit);
        o_next.right_speed = clamp(w_rsp, i_cfg.speed_limit);
        o_next.mode        = n_mode;
        o_next.phase       = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NORMAL;
            r_phase      <= PH_ENTRY;
            r_held_left  <= '0;
            r_held_right <= '0;
        end else if (i_step) begin
            r_mode       <= o_next.mode;
            r_phase      <= o_next.phase;
            r_held_left  <= o_next.left_speed;
            r_held_right <= o_next.right_speed;
        end
    end

`ifndef ASSERT_OFF
    a_normal_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_NORMAL) |-> (r_phase == PH_ENTRY))
        else $error("normal mode outside entry phase");

    a_int_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_LEFT_INT || r_mode == MODE_RIGHT_INT) |->
        (r_phase == PH_ENTRY || r_phase == PH_SEQ0 || r_phase == PH_SEQ1))
        else $error("intersection sequence in a circle-only phase");

    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_mode) && $stable(r_phase) &&
                     $stable(r_held_left) && $stable(r_held_right)))
        else $error("track state moved without an item");
`endif

endmodule

### rtl/core/line_follower_track_controller.sv
// channel   direction  handshake              payload
// -------   ---------  ---------------------  -------------------------------------------
// sample    in         i_valid / o_stall      i_sample_0 .. i_sample_7 (12 bits each)
// result    out        o_valid / i_stall      o_left_speed, o_right_speed, o_track_mode,
//                                             o_seq_phase
// config    in         psel/penable/pwrite    paddr, pwdata, prdata, pready (always high)
//
// one item per cycle while i_stall is low; items pass the sample register, then the result register
// detection and the track state machine work off the sample register in one pass
// reset is synchronous and active low: clears valids, track state, held speeds
// and loads the register defaults
// a stall on the result side holds the result register; the sample register
// still fills, and o_stall rises only when both registers are occupied
module line_follower_track_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [lftc_pkg::SAMPLE_BITS-1:0] i_sample_0,
    input  logic [lftc_pkg::SAMPLE_BITS-1:0] i_sample_1,
    input  logic [lftc_pkg::SAMPLE_BITS-1:0] i_sample_2,
    input  logic [lftc_pkg::SAMPLE_BITS-1:0] i_sample_3,
    input  logic [lftc_pkg::SAMPLE_BITS-1:0] i_sample_4,
    input  logic [lftc_pkg::SAMPLE_BITS-1:0] i_sample_5,
    input  logic [lftc_pkg::SAMPLE_BITS-1:0] i_sample_6,
    input  logic [lftc_pkg::SAMPLE_BITS-1:0] i_sample_7,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [6:0]                     o_left_speed,
    output logic [6:0]                     o_right_speed,
    output logic [1:0]                     o_track_mode,
    output logic [2:0]                     o_seq_phase,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lftc_pkg::ADDR_BITS-1:0] paddr,
    input  logic [lftc_pkg::DATA_BITS-1:0] pwdata,
    output logic [lftc_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready
);
    import lftc_pkg::*;

    t_cfg    w_cfg;
    t_sig    w_sig;
    t_result w_next;

    // sample register
    logic    r_in_valid;
    logic    n_in_valid;
    t_sample r_samples [NUM_SAMPLES];

    // result register
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;

    logic    w_out_load;
    logic    w_advance;
    logic    w_accept;

    // result register is free when empty or being taken this cycle
    assign w_out_load = !r_out_valid || !i_stall;
    assign w_advance  = r_in_valid && w_out_load;
    assign o_stall    = r_in_valid && !w_out_load;
    assign w_accept   = i_valid && !o_stall;

    lftc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lftc_detect u_detect (
        .i_samples (r_samples),
        .o_sig     (w_sig)
    );

    lftc_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_sig   (w_sig),
        .i_cfg   (w_cfg),
        .o_next  (w_next)
    );

    always_comb begin
        priority if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_comb begin
        priority if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_samples[0] <= i_sample_0;
            r_samples[1] <= i_sample_1;
            r_samples[2] <= i_sample_2;
            r_samples[3] <= i_sample_3;
            r_samples[4] <= i_sample_4;
            r_samples[5] <= i_sample_5;
            r_samples[6] <= i_sample_6;
            r_samples[7] <= i_sample_7;
        end
        if (w_advance) begin
            r_out <= w_next;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_left_speed  = r_out.left_speed;
    assign o_right_speed = r_out.right_speed;
    assign o_track_mode  = r_out.mode;
    assign o_seq_phase   = r_out.phase;

`ifndef ASSERT_OFF
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (o_valid && $past(w_next) == r_out))
        else $error("advanced item missing from result register");
`endif

endmodule

### dv/tb_line_follower_track_controller.sv
`timescale 1ns / 100ps

module tb_line_follower_track_controller;
    import lftc_pkg::*;

    // ------------------------------------------------------------------
    // run shape
    // ------------------------------------------------------------------
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int STALL_LIMIT     = 2000;    // cycles with no item moving on either side
    localparam int HOLD_OFF_CYCLES = 60;      // long receiver hold-off, fills the block
    localparam int SETTLE_CYCLES   = 4;       // settle margin after the last owed command
    localparam int DARK_MIN        = 4;       // smallest minimum that still marks a sensor
    localparam int DARK_MAX        = 3276;    // largest minimum whose threshold fits 12 bits
    localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;

    // outer sensors weigh most
    localparam int SENSOR_WEIGHT [NUM_SAMPLES] = '{3, 2, 1, 1, 1, 1, 2, 3};

    typedef t_sample [NUM_SAMPLES-1:0] t_frame;

    // line shapes the random part aims for; the first three are the normal-mode entries
    typedef enum int {
        PAT_FULL, PAT_LEFT, PAT_RIGHT, PAT_MID, PAT_BLANK, PAT_OUT, PAT_NOISE
    } t_pattern;

    // ------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------
    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    t_sample              i_sample_0 = '0;
    t_sample              i_sample_1 = '0;
    t_sample              i_sample_2 = '0;
    t_sample              i_sample_3 = '0;
    t_sample              i_sample_4 = '0;
    t_sample              i_sample_5 = '0;
    t_sample              i_sample_6 = '0;
    t_sample              i_sample_7 = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [6:0]           o_left_speed;
    logic [6:0]           o_right_speed;
    logic [1:0]           o_track_mode;
    logic [2:0]           o_seq_phase;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr   = '0;
    logic [DATA_BITS-1:0] pwdata  = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    line_follower_track_controller dut (.*);

    // ------------------------------------------------------------------
    // predictor state: own copy of the registers and of the track state
    // ------------------------------------------------------------------
    t_cfg   drive_cfg = '{7'd50, 5'd12, 7'd20, 5'd8, 7'd70};
    t_mode  trk_mode  = MODE_NORMAL;
    t_phase trk_phase = PH_ENTRY;
    t_speed held_left  = '0;
    t_speed held_right = '0;

    // wheel commands still owed by the block, oldest first
    t_result pending_cmds [$];

    int mismatches    = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;    // bumped by the sender side to ask for a hold-off
    int hold_taken    = 0;    // last request the receiver side has served
    int hold_left     = 0;

    // ------------------------------------------------------------------
    // directed table: extremes, each track sequence end to end, the
    // no-signal holds and the zero-minimum case; the want column is
    // only trusted where it is obvious, other rows go to the predictor
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [7:0] mask;      // sensors that get the dark value
        t_sample    dark;
        t_sample    bright;
        logic       typed;
        t_result    want;
    } t_directed;

    localparam t_result NO_CHECK = '0;

    t_directed directed_rows [20] = '{
        // all zero after reset: minimum 0, nothing marked, plain normal speeds
        '{8'hFF, 12'd0,    12'd0,    1'b1, '{7'd50, 7'd50, MODE_NORMAL, PH_ENTRY}},
        // all at full scale: every sensor marked, full line enters the circle
        '{8'hFF, 12'd4095, 12'd4095, 1'b0, NO_CHECK},
        '{8'h01, 12'd100,  12'd200,  1'b0, NO_CHECK},   // entry step moves on
        '{8'h01, 12'd100,  12'd200,  1'b0, NO_CHECK},   // no signal, phase kept
        '{8'h18, 12'd100,  12'd200,  1'b0, NO_CHECK},   // mid
        '{8'hFF, 12'd100,  12'd200,  1'b0, NO_CHECK},   // full
        '{8'h18, 12'd100,  12'd200,  1'b0, NO_CHECK},   // mid
        '{8'h7C, 12'd100,  12'd200,  1'b0, NO_CHECK},   // leaving the line
        '{8'h18, 12'd100,  12'd200,  1'b0, NO_CHECK},   // mid closes the circle
        '{8'h0B, 12'd100,  12'd200,  1'b0, NO_CHECK},   // left half
        '{8'h0B, 12'd100,  12'd200,  1'b0, NO_CHECK},
        '{8'hFF, 12'd0,    12'd0,    1'b0, NO_CHECK},   // blank
        '{8'hC0, 12'd100,  12'd200,  1'b0, NO_CHECK},   // no signal while turning
        '{8'h18, 12'd100,  12'd200,  1'b0, NO_CHECK},   // mid, back to normal
        '{8'hD0, 12'd100,  12'd200,  1'b0, NO_CHECK},   // right half
        '{8'hD0, 12'd100,  12'd200,  1'b0, NO_CHECK},
        '{8'hFF, 12'd3,    12'd3,    1'b0, NO_CHECK},   // minimum 3 still marks nothing
        '{8'h18, 12'd4,    12'd5,    1'b0, NO_CHECK},   // smallest marking minimum
        // whole left side dark, no middle: left wheel driven below zero
        '{8'h07, 12'd100,  12'd200,  1'b1, '{7'd0, 7'd50, MODE_NORMAL, PH_ENTRY}},
        '{8'hFF, 12'd4095, 12'd4095, 1'b0, NO_CHECK}
    };

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic t_speed clamp_speed(input int v);
        if (v < 0)
            return '0;
        if (v > int'(drive_cfg.speed_limit))
            return drive_cfg.speed_limit;
        return t_speed'(v);
    endfunction

    // wheel command for one frame; steps the track state as the block does
    function automatic t_result predict_drive(input t_frame f);
        int      low, thr, l_sum, m_sum, r_sum, l_cmd, r_cmd;
        bit      full, l_half, r_half, mid, blank, out_line;
        t_result cmd;
        low = int'(f[0]);
        for (int i = 1; i < NUM_SAMPLES; i++)
            if (f[i] < low)
                low = int'(f[i]);
        thr   = (low * 5) >> 2;
        l_sum = 0;
        m_sum = 0;
        r_sum = 0;
        for (int i = 0; i < NUM_SAMPLES; i++) begin
            if (f[i] < thr) begin
                if (i < 3)
                    l_sum += SENSOR_WEIGHT[i];
                else if (i < 5)
                    m_sum += SENSOR_WEIGHT[i];
                else
                    r_sum += SENSOR_WEIGHT[i];
            end
        end
        full     = l_sum >= 5 && m_sum >= 2 && r_sum >= 5;
        l_half   = l_sum >= 5 && m_sum >= 1;
        r_half   = m_sum >= 1 && r_sum >= 5;
        mid      = l_sum == 0 && m_sum >= 2 && r_sum == 0;
        blank    = l_sum == 0 && m_sum == 0 && r_sum == 0;
        out_line = !full && ((l_sum >= 1 && m_sum >= 2 && r_sum >= 2) ||
                             (l_sum == 0 && m_sum >= 2 && r_sum >= 3));

        // track state
        if (trk_mode == MODE_NORMAL) begin
            if (full)
                trk_mode = MODE_CIRCLE;
            else if (l_half)
                trk_mode = MODE_LEFT_INT;
            else if (r_half)
                trk_mode = MODE_RIGHT_INT;
            trk_phase = PH_ENTRY;
        end else if (trk_phase == PH_ENTRY) begin
            trk_phase = PH_SEQ0;
        end else if (trk_mode == MODE_CIRCLE) begin
            case (trk_phase)
                PH_SEQ0: if (mid)      trk_phase = PH_SEQ1;
                PH_SEQ1: if (full)     trk_phase = PH_SEQ2;
                PH_SEQ2: if (mid)      trk_phase = PH_SEQ3;
                PH_SEQ3: if (out_line) trk_phase = PH_SEQ4;
                PH_SEQ4: if (mid) begin
                    trk_mode  = MODE_NORMAL;
                    trk_phase = PH_ENTRY;
                end
                default: ;
            endcase
        end else begin
            case (trk_phase)
                PH_SEQ0: if (blank) trk_phase = PH_SEQ1;
                PH_SEQ1: if (mid) begin
                    trk_mode  = MODE_NORMAL;
                    trk_phase = PH_ENTRY;
                end
                default: ;
            endcase
        end

        // wheel speeds, sequence entry steps keep the last command
        l_cmd = int'(held_left);
        r_cmd = int'(held_right);
        if (trk_mode == MODE_NORMAL) begin
            l_cmd = int'(drive_cfg.normal_base) - int'(drive_cfg.normal_gain) * l_sum;
            r_cmd = int'(drive_cfg.normal_base) - int'(drive_cfg.normal_gain) * r_sum;
        end else if (trk_mode == MODE_CIRCLE) begin
            if (trk_phase == PH_SEQ0 || trk_phase == PH_SEQ1 || trk_phase == PH_SEQ3) begin
                l_cmd = int'(drive_cfg.slow_base) - int'(drive_cfg.slow_gain) * l_sum;
                r_cmd = int'(drive_cfg.slow_base) - int'(drive_cfg.slow_gain) * r_sum;
            end else if (trk_phase == PH_SEQ2 || trk_phase == PH_SEQ4) begin
                l_cmd = int'(drive_cfg.slow_base);
                r_cmd = 0;
            end
        end else begin
            if (trk_phase == PH_SEQ0) begin
                l_cmd = int'(drive_cfg.slow_base);
                r_cmd = int'(drive_cfg.slow_base);
            end else if (trk_phase == PH_SEQ1) begin
                l_cmd = (trk_mode == MODE_LEFT_INT) ? 0 : int'(drive_cfg.slow_base);
                r_cmd = (trk_mode == MODE_LEFT_INT) ? int'(drive_cfg.slow_base) : 0;
            end
        end
        held_left  = clamp_speed(l_cmd);
        held_right = clamp_speed(r_cmd);

        cmd.left_speed  = held_left;
        cmd.right_speed = held_right;
        cmd.mode        = trk_mode;
        cmd.phase       = trk_phase;
        return cmd;
    endfunction

    // ------------------------------------------------------------------
    // random frames
    // ------------------------------------------------------------------
    // mostly the shape that moves the current sequence on, the rest anything
    function automatic t_pattern pick_pattern();
        if ($urandom_range(99) >= 70)
            return t_pattern'($urandom_range(PAT_NOISE, PAT_FULL));
        if (trk_mode == MODE_NORMAL)
            return t_pattern'($urandom_range(PAT_RIGHT, PAT_FULL));
        if (trk_phase == PH_ENTRY)
            return PAT_NOISE;
        if (trk_mode == MODE_CIRCLE) begin
            case (trk_phase)
                PH_SEQ1: return PAT_FULL;
                PH_SEQ3: return PAT_OUT;
                default: return PAT_MID;
            endcase
        end
        return (trk_phase == PH_SEQ0) ? PAT_BLANK : PAT_MID;
    endfunction

    function automatic t_frame make_frame(input t_pattern p);
        t_frame     f;
        logic [7:0] mask;
        int         dark, thr;
        bit         first;
        f = {$urandom, $urandom, $urandom};
        case ($urandom_range(9))
            0:       dark = DARK_MIN;
            1:       dark = DARK_MAX;
            default: dark = $urandom_range(DARK_MAX, DARK_MIN);
        endcase
        case (p)
            PAT_FULL:  mask = 8'hDB | (8'($urandom) & 8'h24);
            PAT_LEFT:  mask = 8'h03 | (8'($urandom) & 8'hE4) | (8'($urandom_range(3, 1)) << 3);
            PAT_RIGHT: mask = 8'hC0 | (8'($urandom) & 8'h27) | (8'($urandom_range(3, 1)) << 3);
            PAT_MID:   mask = 8'h18;
            PAT_OUT:   mask = 8'h18 | (8'($urandom_range(7, 2)) << 5) | (8'($urandom) & 8'h07);
            default:   mask = 8'h00;
        endcase
        if (p == PAT_BLANK) begin
            // a minimum of 3 or less marks nothing
            f[$urandom_range(NUM_SAMPLES-1, 0)] = t_sample'($urandom_range(3, 0));
        end else if (p != PAT_NOISE) begin
            thr   = (dark * 5) >> 2;
            first = 1'b1;
            for (int i = 0; i < NUM_SAMPLES; i++) begin
                if (mask[i]) begin
                    f[i]  = first ? t_sample'(dark) : t_sample'($urandom_range(thr - 1, dark));
                    first = 1'b0;
                end else begin
                    f[i] = t_sample'($urandom_range(SAMPLE_MAX, thr));
                end
            end
        end
        return f;
    endfunction

    // ------------------------------------------------------------------
    // sample side: random gaps, hold the item until it is taken
    // ------------------------------------------------------------------
    task automatic offer_frame(input t_frame f, input logic typed, input t_result want);
        t_result cmd;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_sample_0 <= f[0];
        i_sample_1 <= f[1];
        i_sample_2 <= f[2];
        i_sample_3 <= f[3];
        i_sample_4 <= f[4];
        i_sample_5 <= f[5];
        i_sample_6 <= f[6];
        i_sample_7 <= f[7];
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        // taken at this edge
        cmd = predict_drive(f);
        pending_cmds.push_back(typed ? want : cmd);
    endtask

    // stop offering and let every owed command come out
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write in a setup then an access phase, only while the block is idle
    task automatic write_reg(input t_reg_idx idx, input logic [DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_NORMAL_BASE: drive_cfg.normal_base = value[6:0];
            REG_NORMAL_GAIN: drive_cfg.normal_gain = value[4:0];
            REG_SLOW_BASE:   drive_cfg.slow_base   = value[6:0];
            REG_SLOW_GAIN:   drive_cfg.slow_gain   = value[4:0];
            REG_SPEED_LIMIT: drive_cfg.speed_limit = value[6:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // result side: random stall, or a long hold-off when asked for
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_request != hold_taken) begin
            hold_left  = HOLD_OFF_CYCLES;
            hold_taken = hold_request;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // compare each wheel command taken with the oldest one owed
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_cmds.size() == 0) begin
                $error("wheel command with none owed: %0d %0d %0d %0d",
                       o_left_speed, o_right_speed, o_track_mode, o_seq_phase);
                mismatches++;
            end else begin
                want = pending_cmds.pop_front();
                if (o_left_speed !== want.left_speed) begin
                    $error("left_speed: expected %0d, got %0d", want.left_speed, o_left_speed);
                    mismatches++;
                end
                if (o_right_speed !== want.right_speed) begin
                    $error("right_speed: expected %0d, got %0d", want.right_speed, o_right_speed);
                    mismatches++;
                end
                if (o_track_mode !== want.mode) begin
                    $error("track_mode: expected %0d, got %0d", want.mode, o_track_mode);
                    mismatches++;
                end
                if (o_seq_phase !== want.phase) begin
                    $error("seq_phase: expected %0d, got %0d", want.phase, o_seq_phase);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: too long with nothing moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        t_frame frame;
        t_cfg   setup;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 18;
        recv_idle_pct = 62;
        foreach (directed_rows[r]) begin
            for (int i = 0; i < NUM_SAMPLES; i++)
                frame[i] = directed_rows[r].mask[i] ? directed_rows[r].dark
                                                    : directed_rows[r].bright;
            offer_frame(frame, directed_rows[r].typed, directed_rows[r].want);
        end

        // phase 0 keeps the reset registers, later phases load new ones
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) begin
                drain_results();
                case (ph)
                    1:       setup = '{7'd127, 5'd31, 7'd127, 5'd31, 7'd127};
                    2:       setup = '{7'd0, 5'd0, 7'd0, 5'd0, 7'd0};
                    4:       setup = '{7'd127, 5'd1, 7'd100, 5'd3, 7'd40};  // bases above the clamp
                    default: setup = t_cfg'($urandom);
                endcase
                write_reg(REG_NORMAL_BASE, 32'(setup.normal_base));
                write_reg(REG_NORMAL_GAIN, 32'(setup.normal_gain));
                write_reg(REG_SLOW_BASE,   32'(setup.slow_base));
                write_reg(REG_SLOW_GAIN,   32'(setup.slow_gain));
                write_reg(REG_SPEED_LIMIT, 32'(setup.speed_limit));
            end
            // slow receiver first, then slow sender, then both at full rate
            send_idle_pct = (ph < 2) ? 18 : (ph < 4) ? 62 : 0;
            recv_idle_pct = (ph < 2) ? 62 : (ph < 4) ? 18 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // receiver holds off while the sender keeps going, block backs up
                if (ph == 4 && n == ITEMS_PER_PHASE / 2)
                    hold_request = hold_request + 1;
                // sender waits for the block to empty mid-stream
                if (ph == 5 && n == ITEMS_PER_PHASE / 2)
                    drain_results();
                offer_frame(make_frame(pick_pattern()), 1'b0, NO_CHECK);
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
